// File: rtl/core/idr_pkg.sv
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types and constants of the interrupt distributor register block.
// ----------------------------------------------------------------------------
package idr_pkg;

   localparam int WORD_W                 = 32;
   localparam int SPACE_W                = 3;
   localparam int INDEX_W                = 4;
   localparam int LOW_W                  = 6;
   localparam int BIT_POS_W              = 5;
   localparam int INDEX_SLOTS            = 16;
   localparam int NUM_GROUPS             = 5;
   localparam int GROUP_W                = 3;
   localparam int RAM_DEPTH              = NUM_GROUPS * INDEX_SLOTS;
   localparam int RAM_ADDR_W             = $clog2(RAM_DEPTH);
   localparam int DEFAULT_NUM_INTERRUPTS = 64;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [SPACE_W-1:0] {
      SP_SET_EN    = 3'd0,
      SP_CLR_EN    = 3'd1,
      SP_SET_PEND  = 3'd2,
      SP_CLR_PEND  = 3'd3,
      SP_PRIORITY  = 3'd4,
      SP_TARGET    = 3'd5,
      SP_TRIGGER   = 3'd6
   } space_type;

   // Rows of the shared word store, sixteen words each.
   typedef enum logic [GROUP_W-1:0] {
      GRP_ENABLE   = 3'd0,
      GRP_PENDING  = 3'd1,
      GRP_PRIORITY = 3'd2,
      GRP_TARGET   = 3'd3,
      GRP_TRIGGER  = 3'd4
   } group_type;

   typedef struct packed {
      logic                wr;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   word;
   } pend_update_type;

   typedef struct packed {
      logic              any;
      logic [LOW_W-1:0]  lowest;
   } scan_type;

endpackage

// File: rtl/core/idr_ram.sv
// ----------------------------------------------------------------------------
// idr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/idr_merge.sv
// ----------------------------------------------------------------------------
// idr_merge
// Range check and read-modify of one register word for a bus transaction.
// ----------------------------------------------------------------------------
module idr_merge
   import idr_pkg::*;
#(
   parameter int NUM_INTERRUPTS = DEFAULT_NUM_INTERRUPTS
) (
   input  logic                op,
   input  logic [SPACE_W-1:0]  space,
   input  logic [INDEX_W-1:0]  word_index,
   input  logic [WORD_W-1:0]   write_data,
   input  logic [WORD_W-1:0]   old_word,
   output logic                wr_en,
   output logic [WORD_W-1:0]   new_word,
   output logic [WORD_W-1:0]   rd_word,
   output logic                index_error
);

   localparam int BIT_WORDS  = (NUM_INTERRUPTS + 31) / 32;
   localparam int BYTE_WORDS = (NUM_INTERRUPTS + 3) / 4;
   localparam int CFG_WORDS  = (NUM_INTERRUPTS + 15) / 16;
   localparam int LIMIT_W    = $clog2(BYTE_WORDS + 1) + 1;

   logic [LIMIT_W-1:0] limit;
   logic [WORD_W-1:0]  live;
   logic [WORD_W-1:0]  masked;
   logic               in_range;

   // Bits that belong to an implemented interrupt. per_log is log2 of the
   // fields in one word, fw_log is log2 of the field width.
   function automatic logic [WORD_W-1:0] live_mask(input logic [INDEX_W-1:0] w,
                                                   input int per_log,
                                                   input int fw_log);
      logic [WORD_W-1:0] m;
      int                idx;
      m = '0;
      for (int j = 0; j < WORD_W; j++) begin
         idx  = (int'(w) << per_log) + (j >> fw_log);
         m[j] = (idx < NUM_INTERRUPTS);
      end
      return m;
   endfunction

   always_comb begin
      limit = '0;
      live  = '0;
      case (space)
         SP_SET_EN, SP_CLR_EN, SP_SET_PEND, SP_CLR_PEND: begin
            limit = LIMIT_W'(BIT_WORDS);
            live  = live_mask(word_index, 5, 0);
         end
         SP_PRIORITY, SP_TARGET: begin
            limit = LIMIT_W'(BYTE_WORDS);
            live  = live_mask(word_index, 2, 3);
         end
         SP_TRIGGER: begin
            limit = LIMIT_W'(CFG_WORDS);
            live  = live_mask(word_index, 4, 1);
         end
         default: begin
            limit = '0;
            live  = '0;
         end
      endcase
   end

   assign in_range    = (LIMIT_W'(word_index) < limit);
   assign masked      = write_data & live;
   assign index_error = !in_range;
   assign wr_en       = in_range && (op == OP_WRITE);
   assign rd_word     = (in_range && (op == OP_READ)) ? old_word : '0;

   always_comb begin
      case (space)
         SP_SET_EN, SP_SET_PEND:               new_word = old_word | masked;
         SP_CLR_EN, SP_CLR_PEND:               new_word = old_word & ~masked;
         SP_PRIORITY, SP_TARGET, SP_TRIGGER:   new_word = masked;
         default:                              new_word = old_word;
      endcase
   end

endmodule

// File: rtl/core/idr_scan.sv
// ----------------------------------------------------------------------------
// idr_scan
// Per-word summary of the pending bits and the lowest pending interrupt.
// ----------------------------------------------------------------------------
module idr_scan
   import idr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pend_update_type upd,
   output scan_type        result
);

   logic                 nz_ff  [INDEX_SLOTS];
   logic [BIT_POS_W-1:0] low_ff [INDEX_SLOTS];
   logic                 nz_in;
   logic [BIT_POS_W-1:0] low_in;
   logic [INDEX_W-1:0]   first;
   logic                 found;

   // Lowest set bit of the word being written.
   always_comb begin
      low_in = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (upd.word[j]) begin
            low_in = BIT_POS_W'(j);
         end
      end
   end

   assign nz_in = |upd.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < INDEX_SLOTS; i++) begin
            nz_ff[i] <= 1'b0;
         end
      end else if (upd.wr) begin
         nz_ff[upd.index]  <= nz_in;
         low_ff[upd.index] <= low_in;
      end
   end

   always_comb begin
      first = '0;
      found = 1'b0;
      for (int i = INDEX_SLOTS - 1; i >= 0; i--) begin
         if (nz_ff[i]) begin
            first = INDEX_W'(i);
            found = 1'b1;
         end
      end
   end

   // Only the low six bits of the interrupt number are reported.
   assign result.any    = found;
   assign result.lowest = found ? {first[0], low_ff[first]} : '0;

endmodule

// File: rtl/core/interrupt_distributor_registers_core.sv
// ----------------------------------------------------------------------------
// interrupt_distributor_registers_core
// Distributor register subset: enable, pending, priority, target and trigger
// configuration words with a lowest-pending-interrupt report.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge where start is high and busy
// is low, and the word store is read at that same edge. In the ST_MODIFY
// state the read word is modified and written back at the end of that
// cycle. In the ST_SCAN state the pending summary, which already holds that
// write, is captured into the result registers. The result is then on the
// rsp_ ports, marked by rsp_valid, which is high for exactly one cycle; it
// is taken at the edge that ends that cycle. busy is already low in that
// cycle, so a new transaction can be started while the result is on the
// ports. The receiver cannot stall the block, and results must be taken
// when rsp_valid is high. A new transaction cannot be accepted until the
// last one has left ST_SCAN, because of the read-modify-write loop around
// the single word store with its registered read data. There is no clearing
// pass after reset: every word of the store carries a valid bit that reset
// clears, and a word that has never been written reads as zero.
//
// All register words live in one 32-bit RAM with sixteen rows per space
// group (enable, pending, priority, target, trigger). The set and clear
// spaces of enable and pending address the same row. A second small
// structure keeps, for every pending word, whether it is nonzero and its
// lowest set bit; the lowest pending interrupt is found from that summary,
// so the report reflects the write of the same transaction. Because only
// one transaction is in flight, a read never overlaps the write-back of an
// earlier transaction and no forwarding is needed.
// ----------------------------------------------------------------------------
module interrupt_distributor_registers_core
   import idr_pkg::*;
#(
   parameter int NUM_INTERRUPTS = DEFAULT_NUM_INTERRUPTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [SPACE_W-1:0]  req_space,
   input  logic [INDEX_W-1:0]  req_word_index,
   input  logic [WORD_W-1:0]   req_write_data,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_read_data,
   output logic                rsp_index_error,
   output logic                rsp_any_pending,
   output logic [LOW_W-1:0]    rsp_lowest_pending
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN
   } state_type;

   state_type               state_ff;
   logic                    op_ff;
   logic [SPACE_W-1:0]      space_ff;
   logic [INDEX_W-1:0]      word_ff;
   logic [WORD_W-1:0]       data_ff;
   logic [RAM_ADDR_W-1:0]   addr_ff;
   logic [WORD_W-1:0]       rd_ff;
   logic                    err_ff;
   logic                    valid_ff [RAM_DEPTH];
   logic                    rsp_valid_ff;
   logic [WORD_W-1:0]       rsp_read_data_ff;
   logic                    rsp_index_error_ff;
   logic                    rsp_any_pending_ff;
   logic [LOW_W-1:0]        rsp_lowest_pending_ff;

   logic                    accept;
   logic [RAM_ADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]       ram_q;
   logic [WORD_W-1:0]       old_word;
   logic                    merge_wr;
   logic                    ram_wr;
   logic [WORD_W-1:0]       new_word;
   logic [WORD_W-1:0]       rd_word;
   logic                    index_error;
   logic                    pend_space;
   pend_update_type         pend_upd;
   scan_type                scan;

   // Row of the word store that a space code addresses. The unused space
   // code always reports an index error, so its row does not matter.
   function automatic group_type space_group(input logic [SPACE_W-1:0] sp);
      group_type g;
      case (sp)
         SP_SET_EN, SP_CLR_EN:     g = GRP_ENABLE;
         SP_SET_PEND, SP_CLR_PEND: g = GRP_PENDING;
         SP_PRIORITY:              g = GRP_PRIORITY;
         SP_TARGET:                g = GRP_TARGET;
         SP_TRIGGER:               g = GRP_TRIGGER;
         default:                  g = GRP_ENABLE;
      endcase
      return g;
   endfunction

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign rd_addr = {space_group(req_space), req_word_index};

   idr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr_ff),
      .wr_data (new_word),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // A word that was never written since reset reads as zero.
   assign old_word = valid_ff[addr_ff] ? ram_q : '0;

   idr_merge #(
      .NUM_INTERRUPTS (NUM_INTERRUPTS)
   ) u_merge (
      .op          (op_ff),
      .space       (space_ff),
      .word_index  (word_ff),
      .write_data  (data_ff),
      .old_word    (old_word),
      .wr_en       (merge_wr),
      .new_word    (new_word),
      .rd_word     (rd_word),
      .index_error (index_error)
   );

   assign ram_wr     = merge_wr && (state_ff == ST_MODIFY);
   assign pend_space = (space_ff == SP_SET_PEND) || (space_ff == SP_CLR_PEND);

   assign pend_upd.wr    = ram_wr && pend_space;
   assign pend_upd.index = word_ff;
   assign pend_upd.word  = new_word;

   idr_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .upd    (pend_upd),
      .result (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (ram_wr) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Sequencer and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MODIFY;
                  op_ff    <= req_op;
                  space_ff <= req_space;
                  word_ff  <= req_word_index;
                  data_ff  <= req_write_data;
                  addr_ff  <= rd_addr;
               end
            end
            ST_MODIFY: begin
               state_ff <= ST_SCAN;
               rd_ff    <= rd_word;
               err_ff   <= index_error;
            end
            ST_SCAN: begin
               state_ff              <= ST_IDLE;
               rsp_valid_ff          <= 1'b1;
               rsp_read_data_ff      <= rd_ff;
               rsp_index_error_ff    <= err_ff;
               rsp_any_pending_ff    <= scan.any;
               rsp_lowest_pending_ff <= scan.lowest;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_index_error    = rsp_index_error_ff;
   assign rsp_any_pending    = rsp_any_pending_ff;
   assign rsp_lowest_pending = rsp_lowest_pending_ff;

`ifndef SYNTH
   a_accept_to_modify: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MODIFY))
      else $error("accepted transaction did not enter the modify cycle");

   a_result_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SCAN))
      else $error("result strobe without a preceding scan cycle");

   a_write_only_in_modify: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (state_ff == ST_MODIFY) && !index_error && (op_ff == OP_WRITE))
      else $error("word store written outside a valid write");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_read_data == '0))
      else $error("out-of-range access returned nonzero data");

   a_none_pending_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_any_pending) |-> (rsp_lowest_pending == '0))
      else $error("lowest pending nonzero while nothing is pending");
`endif

endmodule
